// ----- hw/rtl/qcw_pkg.sv -----
// Shared types and fixed-point constants of the quadratic coordinate warp.
package qcw_pkg;

    localparam int MAG_W       = 24;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int SX_W        = 32;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = 64;
    localparam int ACC_W       = 100;
    localparam int NSTG        = 7;

    localparam int SCALE_SHIFT = 16;
    localparam int SCALE_HALF  = 32768;
    localparam int LIN_SHIFT   = 20;
    localparam int CONST_SHIFT = 48;
    localparam int HI_SHIFT    = 32;
    localparam int FRAC_DROP   = 48;
    localparam int RND_W       = ACC_W - FRAC_DROP;

    localparam logic signed [SX_W-1:0] SX_MAX = 32'sh7fff_ffff;
    localparam logic signed [SX_W-1:0] SX_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-FRAC_DROP){1'b0}}, 1'b1, {(FRAC_DROP-1){1'b0}}};

    localparam logic [CFG_W-1:0] RST_LINE_LIN = 64'd268435456;
    localparam logic [CFG_W-1:0] RST_SAMP_LIN = 64'd1152921504606846976;
    localparam logic [CFG_W-1:0] RST_ZERO     = 64'd0;
    localparam logic [MAG_W-1:0] RST_MAG      = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LIN  = 3'd0,
        CFG_LINE_OC   = 3'd1,
        CFG_LINE_SQ   = 3'd2,
        CFG_SAMP_LIN  = 3'd3,
        CFG_SAMP_OC   = 3'd4,
        CFG_SAMP_SQ   = 3'd5,
        CFG_LINE_MAG  = 3'd6,
        CFG_SAMP_MAG  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] cx;
        logic signed [COEF_W-1:0] cy;
        logic signed [COEF_W-1:0] ck;
        logic signed [COEF_W-1:0] cxy;
        logic signed [COEF_W-1:0] cxx;
        logic signed [COEF_W-1:0] cyy;
    } t_poly_coef;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

endpackage

// ----- hw/rtl/qcw_ifs.sv -----
// Handshake channel interfaces of the quadratic coordinate warp.
interface qcw_coord_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] line_in;
    logic signed [COORD_WIDTH-1:0] sample_in;

    modport source (output valid, output line_in, output sample_in, input ready);
    modport sink (input valid, input line_in, input sample_in, output ready);
endinterface

interface qcw_warp_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] line_out;
    logic signed [COORD_WIDTH-1:0] sample_out;
    logic                          overflow;

    modport source (output valid, output line_out, output sample_out, output overflow,
                    input ready);
    modport sink (input valid, input line_out, input sample_out, input overflow,
                  output ready);
endinterface

interface qcw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/quadratic_coordinate_warp_top.sv -----
// Top level of the quadratic coordinate warp: registers, scaling, squares and handshake.
//
// Usage: each request on i_coord carries a resampled line and sample in signed Q16.8.
// The block scales both by their magnification registers and returns, on o_warp,
// the original-image line and sample from two second-order polynomials, saturated
// to COORD_WIDTH bits, with overflow set when any value was clamped.
// The user writes coefficients and magnifications over i_cfg, one register per request,
// only while no request is in flight; the block does not check this. i_cfg is always ready.
// Throughput is one request per cycle while o_warp.ready is high. A request reaches o_warp.valid
// through seven register stages, the first loaded at the accepting edge:
// coordinate scaling multiply, rounding, square and linear multiplies, split
// coefficient multiplies, term assembly, pair sums, and the final round and saturate
// into the output register.
// Every stage has its own valid bit and advances when the stage after it is empty
// or advancing, so a stalled receiver fills the bubbles first and only then drops
// i_coord.ready; nothing is lost or repeated.
// Reset clears all valid bits and loads the identity mapping with unity magnification.
module quadratic_coordinate_warp_top
    import qcw_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int COEFF_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qcw_coord_if.sink   i_coord,
    qcw_warp_if.source  o_warp,
    qcw_cfg_if.sink     i_cfg
);

    localparam int PW = COORD_WIDTH + MAG_W + 1;

    logic [CFG_W-1:0] r_line_lin, r_line_oc, r_line_sq;
    logic [CFG_W-1:0] r_samp_lin, r_samp_oc, r_samp_sq;
    logic [MAG_W-1:0] r_line_mag, r_samp_mag;

    logic [NSTG-1:0]  r_vld;
    logic [NSTG:0]    w_en;

    logic signed [PW-1:0]     r_lprod, r_sprod;
    logic signed [PW-1:0]     w_lsum, w_ssum, w_lsh, w_ssh;
    logic                     w_lfit, w_sfit;
    logic signed [SX_W-1:0]   n_x, n_y, r_x, r_y;
    logic                     r_sov;
    logic signed [PROD_W-1:0] r_xx, r_yy, r_xy;
    logic                     r_ov2, r_ov3, r_ov4, r_ov5, r_ov6;

    t_pipe_en   w_pen;
    t_poly_coef w_line_coef, w_samp_coef;

    logic signed [COORD_WIDTH-1:0] w_line_val, w_samp_val;
    logic                          w_line_ovf, w_samp_ovf;

    function automatic logic signed [COEF_W-1:0] f_coef(input logic [COEF_W-1:0] v);
        return COEF_W'($signed(v[COEFF_WIDTH-1:0]));
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_lin <= RST_LINE_LIN;
            r_line_oc  <= RST_ZERO;
            r_line_sq  <= RST_ZERO;
            r_samp_lin <= RST_SAMP_LIN;
            r_samp_oc  <= RST_ZERO;
            r_samp_sq  <= RST_ZERO;
            r_line_mag <= RST_MAG;
            r_samp_mag <= RST_MAG;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_LINE_LIN: begin
                    r_line_lin <= i_cfg.data;
                end
                CFG_LINE_OC: begin
                    r_line_oc <= i_cfg.data;
                end
                CFG_LINE_SQ: begin
                    r_line_sq <= i_cfg.data;
                end
                CFG_SAMP_LIN: begin
                    r_samp_lin <= i_cfg.data;
                end
                CFG_SAMP_OC: begin
                    r_samp_oc <= i_cfg.data;
                end
                CFG_SAMP_SQ: begin
                    r_samp_sq <= i_cfg.data;
                end
                CFG_LINE_MAG: begin
                    r_line_mag <= i_cfg.data[MAG_W-1:0];
                end
                CFG_SAMP_MAG: begin
                    r_samp_mag <= i_cfg.data[MAG_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        w_line_coef.cx  = f_coef(r_line_lin[31:0]);
        w_line_coef.cy  = f_coef(r_line_lin[63:32]);
        w_line_coef.ck  = f_coef(r_line_oc[31:0]);
        w_line_coef.cxy = f_coef(r_line_oc[63:32]);
        w_line_coef.cxx = f_coef(r_line_sq[31:0]);
        w_line_coef.cyy = f_coef(r_line_sq[63:32]);
        w_samp_coef.cx  = f_coef(r_samp_lin[31:0]);
        w_samp_coef.cy  = f_coef(r_samp_lin[63:32]);
        w_samp_coef.ck  = f_coef(r_samp_oc[31:0]);
        w_samp_coef.cxy = f_coef(r_samp_oc[63:32]);
        w_samp_coef.cxx = f_coef(r_samp_sq[31:0]);
        w_samp_coef.cyy = f_coef(r_samp_sq[63:32]);
    end

    always_comb begin
        w_en[NSTG] = o_warp.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_coord.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_coord.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_lprod <= PW'(i_coord.line_in) * PW'($signed({1'b0, r_line_mag}));
            r_sprod <= PW'(i_coord.sample_in) * PW'($signed({1'b0, r_samp_mag}));
        end
    end

    always_comb begin
        w_lsum = r_lprod + $signed(PW'(SCALE_HALF));
        w_ssum = r_sprod + $signed(PW'(SCALE_HALF));
        w_lsh  = w_lsum >>> SCALE_SHIFT;
        w_ssh  = w_ssum >>> SCALE_SHIFT;
        w_lfit = (&w_lsh[PW-1:SX_W-1]) || (~|w_lsh[PW-1:SX_W-1]);
        w_sfit = (&w_ssh[PW-1:SX_W-1]) || (~|w_ssh[PW-1:SX_W-1]);
        if (w_lfit) begin
            n_x = w_lsh[SX_W-1:0];
        end else begin
            n_x = w_lsh[PW-1] ? SX_MIN : SX_MAX;
        end
        if (w_sfit) begin
            n_y = w_ssh[SX_W-1:0];
        end else begin
            n_y = w_ssh[PW-1] ? SX_MIN : SX_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_sov <= !(w_lfit && w_sfit);
        end
        if (w_en[2]) begin
            r_xx  <= PROD_W'(r_x) * PROD_W'(r_x);
            r_yy  <= PROD_W'(r_y) * PROD_W'(r_y);
            r_xy  <= PROD_W'(r_x) * PROD_W'(r_y);
            r_ov2 <= r_sov;
        end
        if (w_en[3]) begin
            r_ov3 <= r_ov2;
        end
        if (w_en[4]) begin
            r_ov4 <= r_ov3;
        end
        if (w_en[5]) begin
            r_ov5 <= r_ov4;
        end
        if (w_en[6]) begin
            r_ov6 <= r_ov5;
        end
    end

    always_comb begin
        w_pen.s2 = w_en[2];
        w_pen.s3 = w_en[3];
        w_pen.s4 = w_en[4];
        w_pen.s5 = w_en[5];
        w_pen.s6 = w_en[6];
    end

    qcw_poly #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_line_poly (
        .i_clk   (i_clk),
        .i_en    (w_pen),
        .i_coef  (w_line_coef),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_xx    (r_xx),
        .i_yy    (r_yy),
        .i_xy    (r_xy),
        .o_value (w_line_val),
        .o_ovf   (w_line_ovf)
    );

    qcw_poly #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_samp_poly (
        .i_clk   (i_clk),
        .i_en    (w_pen),
        .i_coef  (w_samp_coef),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_xx    (r_xx),
        .i_yy    (r_yy),
        .i_xy    (r_xy),
        .o_value (w_samp_val),
        .o_ovf   (w_samp_ovf)
    );

    assign o_warp.valid      = r_vld[NSTG-1];
    assign o_warp.line_out   = w_line_val;
    assign o_warp.sample_out = w_samp_val;
    assign o_warp.overflow   = r_ov6 || w_line_ovf || w_samp_ovf;

`ifndef SYNTHESIS
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !o_warp.ready |-> !i_coord.ready)
        else $error("input taken while every stage is full and the output stalls");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_coord.valid && i_coord.ready |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_scale_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && (COORD_WIDTH <= 24) |-> !r_sov)
        else $error("scaled coordinate saturated at a width where it cannot");
`endif

endmodule

// ----- hw/rtl/qcw_poly.sv -----
// Pipelined second-order polynomial in the scaled coordinates, rounded and saturated.
module qcw_poly
    import qcw_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  t_pipe_en                      i_en,
    input  t_poly_coef                    i_coef,
    input  logic signed [SX_W-1:0]        i_x,
    input  logic signed [SX_W-1:0]        i_y,
    input  logic signed [PROD_W-1:0]      i_xx,
    input  logic signed [PROD_W-1:0]      i_yy,
    input  logic signed [PROD_W-1:0]      i_xy,
    output logic signed [COORD_WIDTH-1:0] o_value,
    output logic                          o_ovf
);

    logic signed [PROD_W-1:0]   r_lx, r_ly;
    logic signed [PROD_W:0]     r_xx_lo, r_yy_lo, r_xy_lo;
    logic signed [PROD_W-1:0]   r_xx_hi, r_yy_hi, r_xy_hi;
    logic signed [ACC_W-1:0]    r_lin, n_lin;
    logic signed [ACC_W-1:0]    r_txx, r_tyy, r_txy, r_lin5;
    logic signed [ACC_W-1:0]    n_txx, n_tyy, n_txy;
    logic signed [ACC_W-1:0]    r_s1, r_s2;
    logic signed [ACC_W-1:0]    w_acc;
    logic signed [RND_W-1:0]    w_rnd;
    logic                       w_fit;
    logic signed [COORD_WIDTH-1:0] n_value;
    logic                       n_ovf;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_lx <= PROD_W'(i_coef.cx) * PROD_W'(i_x);
            r_ly <= PROD_W'(i_coef.cy) * PROD_W'(i_y);
        end
    end

    always_comb begin
        n_lin = (ACC_W'(r_lx) <<< LIN_SHIFT) + (ACC_W'(r_ly) <<< LIN_SHIFT)
              + (ACC_W'(i_coef.ck) <<< CONST_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_xx_lo <= (PROD_W+1)'(i_coef.cxx)
                     * (PROD_W+1)'($signed({1'b0, i_xx[HI_SHIFT-1:0]}));
            r_yy_lo <= (PROD_W+1)'(i_coef.cyy)
                     * (PROD_W+1)'($signed({1'b0, i_yy[HI_SHIFT-1:0]}));
            r_xy_lo <= (PROD_W+1)'(i_coef.cxy)
                     * (PROD_W+1)'($signed({1'b0, i_xy[HI_SHIFT-1:0]}));
            r_xx_hi <= PROD_W'(i_coef.cxx) * PROD_W'($signed(i_xx[PROD_W-1:HI_SHIFT]));
            r_yy_hi <= PROD_W'(i_coef.cyy) * PROD_W'($signed(i_yy[PROD_W-1:HI_SHIFT]));
            r_xy_hi <= PROD_W'(i_coef.cxy) * PROD_W'($signed(i_xy[PROD_W-1:HI_SHIFT]));
            r_lin   <= n_lin;
        end
    end

    always_comb begin
        n_txx = (ACC_W'(r_xx_hi) <<< HI_SHIFT) + ACC_W'(r_xx_lo);
        n_tyy = (ACC_W'(r_yy_hi) <<< HI_SHIFT) + ACC_W'(r_yy_lo);
        n_txy = (ACC_W'(r_xy_hi) <<< HI_SHIFT) + ACC_W'(r_xy_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_txx  <= n_txx;
            r_tyy  <= n_tyy;
            r_txy  <= n_txy;
            r_lin5 <= r_lin;
        end
        if (i_en.s5) begin
            r_s1 <= r_txx + r_tyy;
            r_s2 <= r_txy + r_lin5;
        end
    end

    always_comb begin
        w_acc = r_s1 + r_s2 + ACC_HALF;
        w_rnd = w_acc[ACC_W-1:FRAC_DROP];
        w_fit = (&w_rnd[RND_W-1:COORD_WIDTH-1]) || (~|w_rnd[RND_W-1:COORD_WIDTH-1]);
        n_ovf = !w_fit;
        if (w_fit) begin
            n_value = w_rnd[COORD_WIDTH-1:0];
        end else if (w_rnd[RND_W-1]) begin
            n_value = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            o_value <= n_value;
            o_ovf   <= n_ovf;
        end
    end

endmodule

// ----- tb/quadratic_coordinate_warp_top_test.sv -----
// Self-checking testbench of the quadratic coordinate warp with a bit-exact predictor.
`timescale 1ns / 1ps

module quadratic_coordinate_warp_top_test
    import qcw_pkg::*;
();

    localparam int COORD_W     = 24;
    localparam int QUIET_LIMIT = 4000;
    localparam int N_ROWS      = 22;
    localparam int N_PRESETS   = 5;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        logic signed [COORD_W-1:0] line_pos;
        logic signed [COORD_W-1:0] sample_pos;
        logic                      ovf;
    } t_warp_result;

    typedef struct {
        int          preset;
        logic [23:0] ln;
        logic [23:0] sm;
        bit          typed;
        logic [23:0] eln;
        logic [23:0] esm;
        bit          eovf;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    qcw_coord_if #(.COORD_WIDTH(COORD_W)) coord_ch ();
    qcw_warp_if #(.COORD_WIDTH(COORD_W))  warp_ch ();
    qcw_cfg_if                            cfg_ch ();

    quadratic_coordinate_warp_top #(
        .COORD_WIDTH(COORD_W),
        .COEFF_WIDTH(32)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_coord(coord_ch),
        .o_warp(warp_ch),
        .i_cfg(cfg_ch)
    );

    logic [63:0]  cfg_shadow [8];
    t_warp_result expected_warps [$];
    int           fail_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  rx_mode = 0;
    int unsigned  rx_left = 0;
    int unsigned  rx_cnt = 0;

    logic [63:0] preset_regs [N_PRESETS][8] = '{
        '{RST_LINE_LIN, RST_ZERO, RST_ZERO, RST_SAMP_LIN, RST_ZERO, RST_ZERO,
          64'hFFFF_FFFF_FFFF_FFFF, 64'd0},
        '{64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
          64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF,
          64'hFF_FFFF, 64'hFF_FFFF},
        '{64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
          64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
          64'hFF_FFFF, 64'hFF_FFFF},
        '{RST_ZERO, 64'h0000_0000_0000_1234, RST_ZERO, RST_ZERO, 64'h0000_0000_FFFF_FFFB,
          RST_ZERO, 64'd65536, 64'd65536},
        '{64'h0000_0000_0800_0000, RST_ZERO, RST_ZERO, 64'h0800_0000_0000_0000, RST_ZERO,
          RST_ZERO, 64'd32768, 64'd65536}
    };

    // Rows with typed results follow the identity mapping, saturation or a pure constant.
    t_stim_row directed_rows [N_ROWS] = '{
        '{-1, 24'h000000, 24'h000000, 1, 24'h000000, 24'h000000, 0},
        '{-1, 24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000, 0},
        '{-1, 24'h800000, 24'h7FFFFF, 1, 24'h800000, 24'h7FFFFF, 0},
        '{-1, 24'h000001, 24'hFFFFFF, 1, 24'h000001, 24'hFFFFFF, 0},
        '{-1, 24'h555555, 24'hAAAAAA, 1, 24'h555555, 24'hAAAAAA, 0},
        '{ 0, 24'h7FFFFF, 24'h000123, 1, 24'h7FFFFF, 24'h000000, 1},
        '{-1, 24'h800000, 24'hFFFFFF, 1, 24'h800000, 24'h000000, 1},
        '{-1, 24'h000001, 24'h7FFFFF, 1, 24'h000100, 24'h000000, 0},
        '{-1, 24'h000000, 24'h800000, 1, 24'h000000, 24'h000000, 0},
        '{ 1, 24'h7FFFFF, 24'h7FFFFF, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h800000, 24'h800000, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h000001, 24'hFFFFFF, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h000000, 24'h000000, 0, 24'h0, 24'h0, 0},
        '{ 2, 24'h7FFFFF, 24'h800000, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h800000, 24'h7FFFFF, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h000000, 24'h000000, 0, 24'h0, 24'h0, 0},
        '{ 3, 24'h000003, 24'h000004, 1, 24'h001234, 24'hFFFFFB, 0},
        '{-1, 24'h7FFFFF, 24'h800000, 1, 24'h001234, 24'hFFFFFB, 0},
        '{ 4, 24'h000001, 24'h000001, 0, 24'h0, 24'h0, 0},
        '{-1, 24'hFFFFFF, 24'hFFFFFF, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h000003, 24'hFFFFFD, 0, 24'h0, 24'h0, 0},
        '{-1, 24'h000002, 24'h000005, 0, 24'h0, 24'h0, 0}
    };

    function automatic longint scale_coord(input logic [23:0] c, input logic [23:0] mag,
                                           output logic sat);
        longint p;
        p = (longint'($signed(c)) * longint'(mag) + 64'sd32768) >>> 16;
        sat = 1'b0;
        if (p > 64'sd2147483647) begin
            sat = 1'b1;
            p = 64'sd2147483647;
        end else if (p < -64'sd2147483648) begin
            sat = 1'b1;
            p = -64'sd2147483648;
        end
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] poly_eval(input longint x, input longint y,
                                                     input logic [63:0] lin,
                                                     input logic [63:0] oc,
                                                     input logic [63:0] sq,
                                                     output logic sat);
        logic signed [127:0] wx, wy, cx, cy, ck, cxy, cxx, cyy, acc, rnd;
        wx  = x;
        wy  = y;
        cx  = $signed(lin[31:0]);
        cy  = $signed(lin[63:32]);
        ck  = $signed(oc[31:0]);
        cxy = $signed(oc[63:32]);
        cxx = $signed(sq[31:0]);
        cyy = $signed(sq[63:32]);
        acc = ((cx * wx) <<< 20) + ((cy * wy) <<< 20) + (ck <<< 48)
            + cxx * (wx * wx) + cyy * (wy * wy) + cxy * (wx * wy);
        rnd = (acc + (128'sd1 <<< 47)) >>> 48;
        sat = 1'b0;
        if (rnd > 128'sd8388607) begin
            sat = 1'b1;
            return 24'h7FFFFF;
        end
        if (rnd < -128'sd8388608) begin
            sat = 1'b1;
            return 24'h800000;
        end
        return rnd[COORD_W-1:0];
    endfunction

    function automatic t_warp_result warp_predict(input logic [23:0] ln, input logic [23:0] sm);
        t_warp_result r;
        longint x, y;
        logic s0, s1, s2, s3;
        x = scale_coord(ln, cfg_shadow[CFG_LINE_MAG][23:0], s0);
        y = scale_coord(sm, cfg_shadow[CFG_SAMP_MAG][23:0], s1);
        r.line_pos = poly_eval(x, y, cfg_shadow[CFG_LINE_LIN], cfg_shadow[CFG_LINE_OC],
                               cfg_shadow[CFG_LINE_SQ], s2);
        r.sample_pos = poly_eval(x, y, cfg_shadow[CFG_SAMP_LIN], cfg_shadow[CFG_SAMP_OC],
                                 cfg_shadow[CFG_SAMP_SQ], s3);
        r.ovf = s0 | s1 | s2 | s3;
        return r;
    endfunction

    function automatic logic [31:0] pick_coef(input bit linear);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return r;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            6, 7: begin
                if (linear) begin
                    return 32'sh1000_0000 + ($signed(r) >>> 12);
                end
                return $signed(r) >>> $urandom_range(20, 31);
            end
            default: return $signed(r) >>> $urandom_range(8, 31);
        endcase
    endfunction

    function automatic logic [23:0] pick_mag();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 24'h000000;
                    1: return 24'hFFFFFF;
                    2: return 24'h000001;
                    default: return 24'h008000;
                endcase
            end
            default: return 24'd65536 + 24'($urandom_range(0, 16383)) - 24'd8192;
        endcase
    endfunction

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 24'($urandom);
            8: begin
                case ($urandom_range(0, 4))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'h000000;
                    3: return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            9: return 24'($urandom_range(0, 8)) - 24'd4;
            default: return $signed(24'($urandom)) >>> $urandom_range(4, 20);
        endcase
    endfunction

    task automatic send_coord(input logic [23:0] ln, input logic [23:0] sm,
                              input t_warp_result want);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap != 0) begin
                coord_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        coord_ch.valid     <= 1'b1;
        coord_ch.line_in   <= ln;
        coord_ch.sample_in <= sm;
        do @(posedge i_clk); while (!coord_ch.ready);
        expected_warps.push_back(want);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        coord_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (expected_warps.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_shadow[idx] = (idx == CFG_LINE_MAG || idx == CFG_SAMP_MAG) ? {40'd0, d[23:0]} : d;
        @(negedge i_clk);
    endtask

    task automatic load_preset(input int k);
        drain_pipeline();
        for (int i = 0; i < 8; i++) begin
            write_reg(t_cfg_idx'(i), preset_regs[k][i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_random_regs();
        t_cfg_idx idx;
        bit linear;
        drain_pipeline();
        for (int i = 0; i < 8; i++) begin
            idx = t_cfg_idx'(i);
            linear = (idx == CFG_LINE_LIN || idx == CFG_SAMP_LIN);
            if ($urandom_range(0, 3) != 0) begin
                if (idx == CFG_LINE_MAG || idx == CFG_SAMP_MAG) begin
                    write_reg(idx, {32'($urandom), 8'($urandom), pick_mag()});
                end else begin
                    write_reg(idx, {pick_coef(linear), pick_coef(linear)});
                end
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(8, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_cnt <= rx_cnt + 1;
        case (rx_mode)
            0: warp_ch.ready <= 1'b1;
            1: warp_ch.ready <= 1'($urandom_range(0, 1));
            2: warp_ch.ready <= (rx_cnt % 4 != 3);
            default: warp_ch.ready <= (rx_left < 4);
        endcase
    end

    always @(posedge i_clk) begin
        t_warp_result want;
        if (i_rst_n && warp_ch.valid && warp_ch.ready) begin
            if (expected_warps.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: line=%h sample=%h ovf=%b",
                             warp_ch.line_out, warp_ch.sample_out, warp_ch.overflow);
                end
                fail_count++;
            end else begin
                want = expected_warps.pop_front();
                if (warp_ch.line_out !== want.line_pos || warp_ch.sample_out !== want.sample_pos
                        || warp_ch.overflow !== want.ovf) begin
                    if (fail_count < 10) begin
                        $display("mismatch: expected line=%h sample=%h ovf=%b, got %h %h %b",
                                 want.line_pos, want.sample_pos, want.ovf,
                                 warp_ch.line_out, warp_ch.sample_out, warp_ch.overflow);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((coord_ch.valid && coord_ch.ready) || (warp_ch.valid && warp_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_warp_result want;
        logic [23:0] ln, sm;
        i_rst_n            = 1'b0;
        coord_ch.valid     = 1'b0;
        coord_ch.line_in   = '0;
        coord_ch.sample_in = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_LINE_LIN;
        cfg_ch.data        = '0;
        warp_ch.ready      = 1'b0;
        cfg_shadow[CFG_LINE_LIN] = RST_LINE_LIN;
        cfg_shadow[CFG_LINE_OC]  = RST_ZERO;
        cfg_shadow[CFG_LINE_SQ]  = RST_ZERO;
        cfg_shadow[CFG_SAMP_LIN] = RST_SAMP_LIN;
        cfg_shadow[CFG_SAMP_OC]  = RST_ZERO;
        cfg_shadow[CFG_SAMP_SQ]  = RST_ZERO;
        cfg_shadow[CFG_LINE_MAG] = {40'd0, RST_MAG};
        cfg_shadow[CFG_SAMP_MAG] = {40'd0, RST_MAG};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].preset >= 0) begin
                load_preset(directed_rows[r].preset);
            end
            if (directed_rows[r].typed) begin
                want.line_pos   = directed_rows[r].eln;
                want.sample_pos = directed_rows[r].esm;
                want.ovf        = directed_rows[r].eovf;
            end else begin
                want = warp_predict(directed_rows[r].ln, directed_rows[r].sm);
            end
            send_coord(directed_rows[r].ln, directed_rows[r].sm, want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            load_random_regs();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ln = pick_coord();
                sm = pick_coord();
                send_coord(ln, sm, warp_predict(ln, sm));
            end
        end

        drain_pipeline();
        repeat (20) @(posedge i_clk);
        if (expected_warps.size() != 0) begin
            $display("%0d expected results never arrived", expected_warps.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
